>>> sv/afce_pkg.sv
// ----------------------------------------------------------------------------
// afce_pkg
// Shared widths, register indexes and types for the ADC frame channel
// extract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package afce_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int WORD_W       = 32;
    localparam int SAMPLE_W     = 24;
    localparam int VOLTS_W      = 30;
    localparam int CHAN_W       = 8;
    localparam int FRAME_W      = 16;
    localparam int GAIN_W       = 22;
    localparam int WLEFT_W      = 14;
    localparam int GAIN_SHIFT   = 16;
    localparam int PROD_W       = SAMPLE_W + GAIN_W + 1;
    localparam int OUT_DATA_W   = 176;
    localparam int ADDR_W       = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [WORD_W-1:0]  MARKER_WORD    = 32'hFFFF_FFFF;
    localparam logic [CHAN_W-1:0]  CHAN_RESET     = 8'd234;
    localparam logic [FRAME_W-1:0] FRAME_RESET    = 16'd1500;
    localparam logic [GAIN_W-1:0]  GAIN_RESET     = 22'd1832520;

    localparam logic [1:0] REG_CHANNEL_ID      = 2'd0;
    localparam logic [1:0] REG_MAX_FRAME_BYTES = 2'd1;
    localparam logic [1:0] REG_VOLT_GAIN       = 2'd2;

    typedef enum logic [3:0] {
        PH_SEARCH  = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_SIZE    = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [VOLTS_W-1:0]  volts_t;

endpackage

`default_nettype wire

>>> sv/adc_frame_channel_extract_unit.sv
// ----------------------------------------------------------------------------
// adc_frame_channel_extract_unit
// Frame parser for an ADC capture stream: picks one channel's samples,
// scales them to Q24 volts and tracks the two largest and two smallest values.
//
//   channel | group          | payload
//   --------+----------------+---------------------------------------------
//   in      | s_t*           | tdata: stream_word; tuser: new_file
//   out     | m_t*           | tdata: sample, volts, max1, max2, min1, min2
//   config  | APB            | channel_id, max_frame_bytes, volt_gain
//
// One word per cycle while the receiver keeps up; a matching word reaches
// m_tdata through parse, multiply and extreme update into the output register.
// Each stage holds while the next is full and stalled, bubbles are filled.
// Reset clears parser, extremes and valid flags; config registers get defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_frame_channel_extract_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [afce_pkg::WORD_W-1:0]        s_tdata,  // [31:0] stream_word
    input  wire logic                               s_tuser,  // [0] new_file

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [23:0] sample_value, [53:24] volts, [83:54] max_first,
    // [113:84] max_second, [143:114] min_first, [173:144] min_second, pad
    output logic [afce_pkg::OUT_DATA_W-1:0]         m_tdata,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [afce_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [afce_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [afce_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    // configuration
    logic [afce_pkg::CHAN_W-1:0]  chan_reg;
    logic [afce_pkg::FRAME_W-1:0] frame_reg;
    logic [afce_pkg::GAIN_W-1:0]  gain_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg  <= afce_pkg::CHAN_RESET;
            frame_reg <= afce_pkg::FRAME_RESET;
            gain_reg  <= afce_pkg::GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                afce_pkg::REG_CHANNEL_ID:      chan_reg  <= pwdata[afce_pkg::CHAN_W-1:0];
                afce_pkg::REG_MAX_FRAME_BYTES: frame_reg <= pwdata[afce_pkg::FRAME_W-1:0];
                afce_pkg::REG_VOLT_GAIN:       gain_reg  <= pwdata[afce_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            afce_pkg::REG_CHANNEL_ID:
                prdata = afce_pkg::APB_DATA_W'(chan_reg);
            afce_pkg::REG_MAX_FRAME_BYTES:
                prdata = afce_pkg::APB_DATA_W'(frame_reg);
            afce_pkg::REG_VOLT_GAIN:
                prdata = afce_pkg::APB_DATA_W'(gain_reg);
            default:
                prdata = '0;
        endcase
    end

    // stage handshake
    logic p1_v_reg;
    logic p2_v_reg;
    logic out_v_reg;
    logic out_rdy;
    logic p2_rdy;
    logic p1_rdy;
    logic s_fire;

    assign out_rdy  = !out_v_reg | m_tready;
    assign p2_rdy   = !p2_v_reg | out_rdy;
    assign p1_rdy   = !p1_v_reg | p2_rdy;
    assign s_tready = p1_rdy;
    assign s_fire   = s_tvalid & s_tready;

    // frame parser
    afce_pkg::phase_t             phase_reg;
    afce_pkg::phase_t             phase_next;
    afce_pkg::phase_t             phase_cur;
    logic [afce_pkg::WLEFT_W-1:0] wleft_reg;
    logic [afce_pkg::WLEFT_W-1:0] wleft_next;
    logic [afce_pkg::WLEFT_W-1:0] wleft_cur;
    logic [afce_pkg::WLEFT_W-1:0] wleft_dec;
    logic                         hit;
    afce_pkg::sample_t            sample_in;

    assign phase_cur = s_tuser ? afce_pkg::PH_SEARCH : phase_reg;
    assign wleft_cur = s_tuser ? '0 : wleft_reg;
    assign wleft_dec = (wleft_cur != '0) ? wleft_cur - 1'b1 : wleft_cur;
    assign sample_in = afce_pkg::SAMPLE_W'(
        signed'(s_tdata[afce_pkg::SAMPLE_BITS-1:0]));

    always_comb
    begin
        phase_next = phase_cur;
        wleft_next = wleft_cur;
        hit        = 1'b0;
        unique case (phase_cur)
            afce_pkg::PH_SEARCH:
            begin
                if (s_tdata == afce_pkg::MARKER_WORD)
                    phase_next = afce_pkg::PH_HEADER;
            end
            afce_pkg::PH_HEADER:
            begin
                phase_next = s_tdata[afce_pkg::WORD_W-1] ? afce_pkg::PH_SEARCH
                                                          : afce_pkg::PH_SIZE;
            end
            afce_pkg::PH_SIZE:
            begin
                if ((s_tdata > afce_pkg::WORD_W'(frame_reg)) ||
                    (s_tdata[afce_pkg::WORD_W-1:2] == '0))
                begin
                    phase_next = afce_pkg::PH_SEARCH;
                end
                else
                begin
                    wleft_next = s_tdata[afce_pkg::WLEFT_W+1:2];
                    phase_next = afce_pkg::PH_PAYLOAD;
                end
            end
            afce_pkg::PH_PAYLOAD:
            begin
                wleft_next = wleft_dec;
                if (wleft_dec == '0)
                    phase_next = afce_pkg::PH_SEARCH;
                hit = (s_tdata[afce_pkg::WORD_W-1 -: afce_pkg::CHAN_W] == chan_reg);
            end
            default:
            begin
                phase_next = afce_pkg::PH_SEARCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= afce_pkg::PH_SEARCH;
            wleft_reg <= '0;
        end
        else if (s_fire)
        begin
            phase_reg <= phase_next;
            wleft_reg <= wleft_next;
        end
    end

    // stage 1: parsed item
    logic              p1_clr_reg;
    logic              p1_hit_reg;
    afce_pkg::sample_t p1_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg   <= 1'b0;
            p1_clr_reg <= 1'b0;
            p1_hit_reg <= 1'b0;
        end
        else if (p1_rdy)
        begin
            p1_v_reg   <= s_fire & (hit | s_tuser);
            p1_clr_reg <= s_tuser;
            p1_hit_reg <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_rdy)
            p1_sample_reg <= sample_in;
    end

    // stage 2: scale to volts
    logic signed [afce_pkg::PROD_W-1:0] prod;
    logic                               p2_clr_reg;
    logic                               p2_hit_reg;
    afce_pkg::sample_t                  p2_sample_reg;
    afce_pkg::volts_t                   p2_volts_reg;

    assign prod = afce_pkg::PROD_W'(p1_sample_reg) *
                  afce_pkg::PROD_W'(signed'({1'b0, gain_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_v_reg   <= 1'b0;
            p2_clr_reg <= 1'b0;
            p2_hit_reg <= 1'b0;
        end
        else if (p2_rdy)
        begin
            p2_v_reg   <= p1_v_reg;
            p2_clr_reg <= p1_clr_reg;
            p2_hit_reg <= p1_hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_rdy)
        begin
            p2_sample_reg <= p1_sample_reg;
            p2_volts_reg  <= prod[afce_pkg::GAIN_SHIFT +: afce_pkg::VOLTS_W];
        end
    end

    // stage 3: extremes and output register
    afce_pkg::volts_t max1_reg;
    afce_pkg::volts_t max2_reg;
    afce_pkg::volts_t min1_reg;
    afce_pkg::volts_t min2_reg;
    afce_pkg::volts_t max1_cur;
    afce_pkg::volts_t max2_cur;
    afce_pkg::volts_t min1_cur;
    afce_pkg::volts_t min2_cur;
    afce_pkg::volts_t max1_next;
    afce_pkg::volts_t max2_next;
    afce_pkg::volts_t min1_next;
    afce_pkg::volts_t min2_next;
    logic             p2_take;

    assign p2_take  = p2_v_reg & out_rdy;
    assign max1_cur = p2_clr_reg ? '0 : max1_reg;
    assign max2_cur = p2_clr_reg ? '0 : max2_reg;
    assign min1_cur = p2_clr_reg ? '0 : min1_reg;
    assign min2_cur = p2_clr_reg ? '0 : min2_reg;

    always_comb
    begin
        max1_next = max1_cur;
        max2_next = max2_cur;
        min1_next = min1_cur;
        min2_next = min2_cur;
        if (p2_hit_reg)
        begin
            if (p2_volts_reg > max1_cur)
            begin
                max2_next = max1_cur;
                max1_next = p2_volts_reg;
            end
            else if ((p2_volts_reg < max1_cur) && (p2_volts_reg > max2_cur))
            begin
                max2_next = p2_volts_reg;
            end
            if (p2_volts_reg < min1_cur)
            begin
                min2_next = min1_cur;
                min1_next = p2_volts_reg;
            end
            else if ((p2_volts_reg > min1_cur) && (p2_volts_reg < min2_cur))
            begin
                min2_next = p2_volts_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max1_reg <= '0;
            max2_reg <= '0;
            min1_reg <= '0;
            min2_reg <= '0;
        end
        else if (p2_take)
        begin
            max1_reg <= max1_next;
            max2_reg <= max2_next;
            min1_reg <= min1_next;
            min2_reg <= min2_next;
        end
    end

    afce_pkg::sample_t o_sample_reg;
    afce_pkg::volts_t  o_volts_reg;
    afce_pkg::volts_t  o_max1_reg;
    afce_pkg::volts_t  o_max2_reg;
    afce_pkg::volts_t  o_min1_reg;
    afce_pkg::volts_t  o_min2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_rdy)
            out_v_reg <= p2_v_reg & p2_hit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            o_sample_reg <= p2_sample_reg;
            o_volts_reg  <= p2_volts_reg;
            o_max1_reg   <= max1_next;
            o_max2_reg   <= max2_next;
            o_min1_reg   <= min1_next;
            o_min2_reg   <= min2_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, o_min2_reg, o_min1_reg, o_max2_reg, o_max1_reg,
                       o_volts_reg, o_sample_reg};

`ifndef ASSERT_OFF
    a_payload_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == afce_pkg::PH_PAYLOAD) |-> (wleft_reg != '0))
        else $error("payload phase with no words left");

    a_last_word_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !s_tuser && (phase_reg == afce_pkg::PH_PAYLOAD) &&
         (wleft_reg == afce_pkg::WLEFT_W'(1)))
        |=> (phase_reg == afce_pkg::PH_SEARCH))
        else $error("frame did not end after last payload word");

    a_max_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((o_max1_reg >= o_max2_reg) && (o_max1_reg >= o_volts_reg)
                      && (o_max1_reg >= 0)))
        else $error("largest values out of order");

    a_min_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((o_min1_reg <= o_min2_reg) && (o_min1_reg <= o_volts_reg)
                      && (o_min1_reg <= 0)))
        else $error("smallest values out of order");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for adc_frame_channel_extract_unit. A driver process
// feeds stream words from a backlog queue. Every accepted transfer goes
// through a cycle-level copy of the frame parser and the extreme trackers.
// The copy queues the sample records that are due. A monitor process
// compares each output transfer field by field with the oldest record due.
// Several register settings are run, extremes among them. Both sides idle at
// random, and the receiver makes one long hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_GAP        = 17;
    localparam int PIPE_SETTLE    = 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 140;

    typedef struct packed {
        logic                        new_file;
        logic [afce_pkg::WORD_W-1:0] word;
    } stream_item_t;

    typedef struct {
        afce_pkg::sample_t sample;
        afce_pkg::volts_t  volts;
        afce_pkg::volts_t  max1;
        afce_pkg::volts_t  max2;
        afce_pkg::volts_t  min1;
        afce_pkg::volts_t  min2;
    } channel_sample_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [afce_pkg::WORD_W-1:0]     s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [afce_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [afce_pkg::ADDR_W-1:0]     paddr    = '0;
    logic [afce_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [afce_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // parser and extreme tracker copy
    logic [afce_pkg::CHAN_W-1:0]  chan_sel    = afce_pkg::CHAN_RESET;
    logic [afce_pkg::FRAME_W-1:0] frame_limit = afce_pkg::FRAME_RESET;
    logic [afce_pkg::GAIN_W-1:0]  gain_q16    = afce_pkg::GAIN_RESET;
    afce_pkg::phase_t             parse_state = afce_pkg::PH_SEARCH;
    logic [afce_pkg::WLEFT_W-1:0] words_to_go = '0;
    afce_pkg::volts_t             max1        = '0;
    afce_pkg::volts_t             max2        = '0;
    afce_pkg::volts_t             min1        = '0;
    afce_pkg::volts_t             min2        = '0;

    channel_sample_t samples_due[$];
    stream_item_t    stream_backlog[$];
    stream_item_t    offered;

    bit tx_gaps_on   = 1'b1;
    bit rx_gaps_on   = 1'b1;
    bit tx_busy      = 1'b0;
    int tx_wait      = 0;
    int rx_stall     = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int quiet_cycles = 0;
    int words_queued = 0;
    int error_count  = 0;

    adc_frame_channel_extract_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic clear_stream_state();
        parse_state = afce_pkg::PH_SEARCH;
        words_to_go = '0;
        max1        = '0;
        max2        = '0;
        min1        = '0;
        min2        = '0;
    endtask

    task automatic parse_word(input stream_item_t item);
        afce_pkg::sample_t                  smp;
        logic signed [afce_pkg::PROD_W-1:0] prod;
        logic signed [afce_pkg::PROD_W-1:0] scaled;
        afce_pkg::volts_t                   v;
        channel_sample_t                    rec;
        if (item.new_file)
            clear_stream_state();
        case (parse_state)
            afce_pkg::PH_SEARCH:
            begin
                if (item.word == afce_pkg::MARKER_WORD)
                    parse_state = afce_pkg::PH_HEADER;
            end
            afce_pkg::PH_HEADER:
            begin
                parse_state = item.word[afce_pkg::WORD_W-1] ? afce_pkg::PH_SEARCH
                                                            : afce_pkg::PH_SIZE;
            end
            afce_pkg::PH_SIZE:
            begin
                if (item.word > frame_limit || item.word[afce_pkg::WORD_W-1:2] == '0)
                    parse_state = afce_pkg::PH_SEARCH;
                else
                begin
                    words_to_go = item.word[afce_pkg::WLEFT_W+1:2];
                    parse_state = afce_pkg::PH_PAYLOAD;
                end
            end
            afce_pkg::PH_PAYLOAD:
            begin
                if (words_to_go != '0)
                    words_to_go = words_to_go - 1'b1;
                if (words_to_go == '0)
                    parse_state = afce_pkg::PH_SEARCH;
                if (item.word[afce_pkg::WORD_W-1 -: afce_pkg::CHAN_W] == chan_sel)
                begin
                    smp    = item.word[afce_pkg::SAMPLE_W-1:0];
                    prod   = afce_pkg::PROD_W'(smp) *
                             afce_pkg::PROD_W'($signed({1'b0, gain_q16}));
                    scaled = prod >>> afce_pkg::GAIN_SHIFT;
                    v      = scaled[afce_pkg::VOLTS_W-1:0];
                    if (v > max1)
                    begin
                        max2 = max1;
                        max1 = v;
                    end
                    else if (v < max1 && v > max2)
                        max2 = v;
                    if (v < min1)
                    begin
                        min2 = min1;
                        min1 = v;
                    end
                    else if (v > min1 && v < min2)
                        min2 = v;
                    rec.sample = smp;
                    rec.volts  = v;
                    rec.max1   = max1;
                    rec.max2   = max2;
                    rec.min1   = min1;
                    rec.min2   = min2;
                    samples_due.push_back(rec);
                end
            end
            default:
            begin
                parse_state = afce_pkg::PH_SEARCH;
            end
        endcase
    endtask

    task automatic compare_field(input string name,
                                 input logic signed [afce_pkg::VOLTS_W-1:0] want,
                                 input logic signed [afce_pkg::VOLTS_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_sample_out(input logic [afce_pkg::OUT_DATA_W-1:0] data);
        channel_sample_t want;
        if (samples_due.size() == 0)
        begin
            $display("%0t: output transfer expected none got %h", $time, data);
            error_count++;
        end
        else
        begin
            want = samples_due.pop_front();
            compare_field("sample_value", want.sample,
                          $signed(data[afce_pkg::SAMPLE_W-1:0]));
            compare_field("volts", want.volts,
                          $signed(data[afce_pkg::SAMPLE_W +: afce_pkg::VOLTS_W]));
            compare_field("max_first", want.max1,
                          $signed(data[afce_pkg::SAMPLE_W+afce_pkg::VOLTS_W
                                       +: afce_pkg::VOLTS_W]));
            compare_field("max_second", want.max2,
                          $signed(data[afce_pkg::SAMPLE_W+2*afce_pkg::VOLTS_W
                                       +: afce_pkg::VOLTS_W]));
            compare_field("min_first", want.min1,
                          $signed(data[afce_pkg::SAMPLE_W+3*afce_pkg::VOLTS_W
                                       +: afce_pkg::VOLTS_W]));
            compare_field("min_second", want.min2,
                          $signed(data[afce_pkg::SAMPLE_W+4*afce_pkg::VOLTS_W
                                       +: afce_pkg::VOLTS_W]));
        end
    endtask

    // driver: gap after each item, prediction on every accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            tx_wait  = 0;
            tx_busy  = 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_word(offered);
                tx_busy = 1'b0;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (stream_backlog.size() != 0)
                begin
                    offered = stream_backlog.pop_front();
                    tx_busy = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= offered.word;
                    s_tuser  <= offered.new_file;
                    tx_wait  = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random stalls, long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_stall     = 0;
            holds_served = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_sample_out(m_tdata);
                rx_stall = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (holds_served != holds_asked)
            begin
                holds_served++;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [afce_pkg::WORD_W-1:0] w, input logic nf);
        stream_item_t item;
        item.word     = w;
        item.new_file = nf;
        stream_backlog.push_back(item);
        words_queued++;
    endtask

    task automatic settle();
        while (stream_backlog.size() != 0 || tx_busy || samples_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [afce_pkg::APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            afce_pkg::REG_CHANNEL_ID:      chan_sel    = value[afce_pkg::CHAN_W-1:0];
            afce_pkg::REG_MAX_FRAME_BYTES: frame_limit = value[afce_pkg::FRAME_W-1:0];
            afce_pkg::REG_VOLT_GAIN:       gain_q16    = value[afce_pkg::GAIN_W-1:0];
            default:                       ;
        endcase
    endtask

    task automatic configure(input logic [afce_pkg::CHAN_W-1:0] chan,
                             input logic [afce_pkg::FRAME_W-1:0] limit,
                             input logic [afce_pkg::GAIN_W-1:0] gain);
        write_reg(afce_pkg::REG_CHANNEL_ID, afce_pkg::APB_DATA_W'(chan));
        write_reg(afce_pkg::REG_MAX_FRAME_BYTES, afce_pkg::APB_DATA_W'(limit));
        write_reg(afce_pkg::REG_VOLT_GAIN, afce_pkg::APB_DATA_W'(gain));
    endtask

    task automatic randomize_idling();
        tx_gaps_on = $urandom_range(0, 3) != 0;
        rx_gaps_on = $urandom_range(0, 3) != 0;
    endtask

    function automatic logic [afce_pkg::WORD_W-1:0] payload_word(input int match_pct);
        logic [afce_pkg::CHAN_W-1:0]   chan;
        logic [afce_pkg::SAMPLE_W-1:0] raw;
        chan = ($urandom_range(0, 99) < match_pct) ? chan_sel : afce_pkg::CHAN_W'($urandom);
        case ($urandom_range(0, 11))
            0:       raw = 24'h7F_FFFF;
            1:       raw = 24'h80_0000;
            2:       raw = 24'hFF_FFFF;
            3:       raw = 24'h00_0000;
            4:       raw = 24'h80_0001;
            5:       raw = afce_pkg::SAMPLE_W'($urandom_range(0, 255));
            default: raw = afce_pkg::SAMPLE_W'($urandom);
        endcase
        return {chan, raw};
    endfunction

    function automatic logic [afce_pkg::WORD_W-1:0] good_header();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    function automatic int frame_words_cap();
        return (frame_limit / 4 < 12) ? frame_limit / 4 : 12;
    endfunction

    task automatic queue_frame(input int n_words, input int match_pct);
        logic [afce_pkg::WORD_W-1:0] size_bytes;
        logic [afce_pkg::WORD_W-1:0] w;
        int                          extra;
        push_word(afce_pkg::MARKER_WORD, $urandom_range(0, 15) == 0);
        push_word(good_header(), 1'b0);
        size_bytes = 4 * n_words;
        extra      = $urandom_range(0, 3);
        if (size_bytes + extra <= frame_limit)
            size_bytes = size_bytes + extra;
        push_word(size_bytes, 1'b0);
        w = payload_word(match_pct);
        for (int k = 0; k < n_words; k++)
        begin
            if (k == 0 || $urandom_range(0, 7) != 0)
                w = payload_word(match_pct);
            push_word(w, 1'b0);
        end
    endtask

    task automatic queue_broken();
        int n;
        push_word(afce_pkg::MARKER_WORD, 1'b0);
        case ($urandom_range(0, 3))
            0:
            begin
                push_word(($urandom_range(0, 3) == 0) ? afce_pkg::MARKER_WORD
                                                      : (32'h8000_0000 | $urandom),
                          1'b0);
            end
            1:
            begin
                push_word(good_header(), 1'b0);
                if ($urandom_range(0, 3) == 0 || frame_limit == 16'hFFFF)
                    push_word(32'hFFFF_FFFF - $urandom_range(0, 65535), 1'b0);
                else
                    push_word(32'(frame_limit) + 1 + $urandom_range(0, 4000), 1'b0);
            end
            2:
            begin
                push_word(good_header(), 1'b0);
                push_word($urandom_range(0, 3), 1'b0);
            end
            default:
            begin
                push_word(good_header(), 1'b0);
                if (frame_limit >= 4)
                begin
                    n = $urandom_range(1, frame_words_cap());
                    push_word(4 * n, 1'b0);
                    repeat ($urandom_range(0, n - 1)) push_word(payload_word(70), 1'b0);
                end
                push_word(($urandom_range(0, 1) == 0) ? afce_pkg::MARKER_WORD : $urandom,
                          1'b1);
            end
        endcase
    endtask

    task automatic queue_random_traffic(input int target);
        int start;
        int roll;
        start = words_queued;
        while (words_queued - start < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75 && frame_limit >= 4)
                queue_frame($urandom_range(1, frame_words_cap()), 65);
            else if (roll < 88)
                queue_broken();
            else
                repeat ($urandom_range(1, 4)) push_word($urandom, $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values; boundary samples, rejected header that looks
        // like a marker, oversize and short frames, new file, repeated values
        push_word(afce_pkg::MARKER_WORD, 1'b0);
        push_word(32'h7FFF_FFFF, 1'b0);
        push_word(32'd19, 1'b0);
        push_word(32'hEA7F_FFFF, 1'b0);
        push_word(32'hEA80_0000, 1'b0);
        push_word(32'hEA00_0000, 1'b0);
        push_word(32'hE912_3456, 1'b0);
        push_word(afce_pkg::MARKER_WORD, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'd8, 1'b0);
        push_word(32'hEA00_0001, 1'b0);
        push_word(afce_pkg::MARKER_WORD, 1'b0);
        push_word(32'd0, 1'b0);
        push_word(32'd1501, 1'b0);
        push_word(afce_pkg::MARKER_WORD, 1'b1);
        push_word(32'd0, 1'b0);
        push_word(32'd3, 1'b0);
        push_word(afce_pkg::MARKER_WORD, 1'b0);
        push_word(32'h8000_0000 - 1, 1'b0);
        push_word(32'd16, 1'b0);
        push_word(32'hEAFF_FFFF, 1'b0);
        push_word(32'hEA7F_FFFF, 1'b0);
        push_word(32'hEA7F_FFFF, 1'b0);
        push_word(32'hEAFF_FFFF, 1'b0);
        settle();

        // widest settings; a maximal frame cut short by a new file
        configure('0, 16'hFFFF, {afce_pkg::GAIN_W{1'b1}});
        randomize_idling();
        push_word(afce_pkg::MARKER_WORD, 1'b0);
        push_word(32'd0, 1'b0);
        push_word(32'd65535, 1'b0);
        repeat (30) push_word(payload_word(70), 1'b0);
        push_word(afce_pkg::MARKER_WORD, 1'b1);
        queue_random_traffic(PHASE_WORDS);
        settle();

        configure({afce_pkg::CHAN_W{1'b1}}, '0, '0);
        randomize_idling();
        queue_random_traffic(PHASE_WORDS / 2);
        settle();

        configure({afce_pkg::CHAN_W{1'b1}}, 16'd64, '0);
        randomize_idling();
        queue_random_traffic(PHASE_WORDS);
        settle();

        // back to reset values: largest frame, long receiver hold-off,
        // sender pause in the middle of a frame
        configure(afce_pkg::CHAN_RESET, afce_pkg::FRAME_RESET, afce_pkg::GAIN_RESET);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b1;
        queue_frame(afce_pkg::FRAME_RESET / 4, 50);
        settle();
        holds_asked++;
        queue_frame(60, 100);
        settle();
        tx_gaps_on = 1'b1;
        push_word(afce_pkg::MARKER_WORD, 1'b0);
        push_word(32'd5, 1'b0);
        push_word(32'd32, 1'b0);
        repeat (4) push_word(payload_word(80), 1'b0);
        settle();
        repeat (4) push_word(payload_word(80), 1'b0);
        settle();

        repeat (4)
        begin
            configure(afce_pkg::CHAN_W'($urandom),
                      afce_pkg::FRAME_W'($urandom_range(4, 2000)),
                      afce_pkg::GAIN_W'($urandom));
            randomize_idling();
            queue_random_traffic(PHASE_WORDS);
            settle();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
